### design/mkte_pkg.sv
// Shared types, key codes, command codes and character tables for the multitap editor.
// No dependencies; every other design file but mkte_ram refers to it by scoped names.
package mkte_pkg;

   typedef struct packed {
      logic       operation;
      logic [3:0] key_code;
   } req_item_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] char_byte;
      logic       last_of_run;
      logic [3:0] cursor_now;
      logic [3:0] length_now;
      logic       upper_now;
      logic       tap_pending;
   } rsp_item_type;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   localparam logic [3:0] KEY_LEFT   = 4'd3;
   localparam logic [3:0] KEY_RIGHT  = 4'd7;
   localparam logic [3:0] KEY_DEL    = 4'd11;
   localparam logic [3:0] KEY_CASE   = 4'd12;
   localparam logic [3:0] KEY_SEND   = 4'd14;
   localparam logic [3:0] KEY_COMMIT = 4'd15;

   localparam logic [4:0]  NO_KEY        = 5'd16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd800;
   localparam logic [6:0]  CASE_OFFSET   = 7'd32;
   localparam logic [6:0]  CHAR_UPPER_A  = 7'h41;
   localparam logic [6:0]  CHAR_UPPER_Z  = 7'h5A;

   // datapath commands
   localparam logic [3:0] CMD_NONE      = 4'd0;
   localparam logic [3:0] CMD_TICK      = 4'd1;
   localparam logic [3:0] CMD_SIMPLE    = 4'd2;
   localparam logic [3:0] CMD_REPLACE   = 4'd3;
   localparam logic [3:0] CMD_INS_INIT  = 4'd4;
   localparam logic [3:0] CMD_INS_STEP  = 4'd5;
   localparam logic [3:0] CMD_INS_DONE  = 4'd6;
   localparam logic [3:0] CMD_DEL_INIT  = 4'd7;
   localparam logic [3:0] CMD_DEL_STEP  = 4'd8;
   localparam logic [3:0] CMD_DEL_DONE  = 4'd9;
   localparam logic [3:0] CMD_SEND_INIT = 4'd10;
   localparam logic [3:0] CMD_SEND_STEP = 4'd11;
   localparam logic [3:0] CMD_STATUS    = 4'd12;

   typedef struct packed {
      logic       latch;
      logic       cfg_write;
      logic [3:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_char;
      logic is_repeat;
      logic key_del;
      logic is_send;
      logic full;
      logic at_end;
      logic cur_zero;
      logic len_zero;
      logic ins_last;
      logic del_last;
      logic send_last;
   } dp_status_type;

   function automatic logic [2:0] group_len(input logic [3:0] key);
      logic [2:0] len;
      case (key)
         4'd0, 4'd8, 4'd10:                len = 3'd5;
         4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd9: len = 3'd4;
         4'd13:                            len = 3'd2;
         default:                          len = 3'd0;
      endcase
      return len;
   endfunction

   // characters packed first-in-LSB
   function automatic logic [6:0] group_char(input logic [3:0] key, input logic [2:0] pos);
      logic [34:0] row;
      case (key)
         4'd0:    row = {7'h3F, 7'h21, 7'h2C, 7'h2E, 7'h31};
         4'd1:    row = {7'h00, 7'h32, 7'h43, 7'h42, 7'h41};
         4'd2:    row = {7'h00, 7'h33, 7'h46, 7'h45, 7'h44};
         4'd4:    row = {7'h00, 7'h34, 7'h49, 7'h48, 7'h47};
         4'd5:    row = {7'h00, 7'h35, 7'h4C, 7'h4B, 7'h4A};
         4'd6:    row = {7'h00, 7'h36, 7'h4F, 7'h4E, 7'h4D};
         4'd8:    row = {7'h37, 7'h53, 7'h52, 7'h51, 7'h50};
         4'd9:    row = {7'h00, 7'h38, 7'h56, 7'h55, 7'h54};
         4'd10:   row = {7'h39, 7'h5A, 7'h59, 7'h58, 7'h57};
         4'd13:   row = {7'h00, 7'h00, 7'h00, 7'h30, 7'h20};
         default: row = '0;
      endcase
      if (pos > 3'd4) begin
         return 7'h00;
      end
      return row[7*pos +: 7];
   endfunction

   function automatic logic [6:0] fold_case(input logic [6:0] ch, input logic upper);
      if (!upper && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         return ch + CASE_OFFSET;
      end
      return ch;
   endfunction

endpackage

### design/mkte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mkte_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 13,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mkte_ctrl.sv
// Sequencer for the multitap editor: decodes a request and steps the datapath.
// Depends on mkte_pkg.
module mkte_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  mkte_pkg::dp_status_type status,
   output mkte_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_INS_STEP  = 3'd2;
   localparam logic [2:0] S_INS_FIN   = 3'd3;
   localparam logic [2:0] S_DEL_STEP  = 3'd4;
   localparam logic [2:0] S_DEL_FIN   = 3'd5;
   localparam logic [2:0] S_SEND_STEP = 3'd6;
   localparam logic [2:0] S_STATUS    = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;

   always_comb begin
      state_in      = state_ff;
      cmd.latch     = 1'b0;
      cmd.cfg_write = csr_valid && !busy;
      cmd.op        = mkte_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch = start;
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (status.is_tick) begin
               cmd.op   = mkte_pkg::CMD_TICK;
               state_in = S_IDLE;
            end else if (status.is_char && status.is_repeat) begin
               cmd.op   = mkte_pkg::CMD_REPLACE;
               state_in = S_STATUS;
            end else if (status.is_char && (status.full || status.at_end)) begin
               cmd.op   = mkte_pkg::CMD_INS_DONE;
               state_in = S_STATUS;
            end else if (status.is_char) begin
               cmd.op   = mkte_pkg::CMD_INS_INIT;
               state_in = S_INS_STEP;
            end else if (status.key_del && !status.cur_zero && status.at_end) begin
               cmd.op   = mkte_pkg::CMD_DEL_DONE;
               state_in = S_STATUS;
            end else if (status.key_del && !status.cur_zero) begin
               cmd.op   = mkte_pkg::CMD_DEL_INIT;
               state_in = S_DEL_STEP;
            end else if (status.is_send && !status.len_zero) begin
               cmd.op   = mkte_pkg::CMD_SEND_INIT;
               state_in = S_SEND_STEP;
            end else begin
               cmd.op   = mkte_pkg::CMD_SIMPLE;
               state_in = S_STATUS;
            end
         end
         S_INS_STEP: begin
            cmd.op = mkte_pkg::CMD_INS_STEP;
            if (status.ins_last) begin
               state_in = S_INS_FIN;
            end
         end
         S_INS_FIN: begin
            cmd.op   = mkte_pkg::CMD_INS_DONE;
            state_in = S_STATUS;
         end
         S_DEL_STEP: begin
            cmd.op = mkte_pkg::CMD_DEL_STEP;
            if (status.del_last) begin
               state_in = S_DEL_FIN;
            end
         end
         S_DEL_FIN: begin
            cmd.op   = mkte_pkg::CMD_DEL_DONE;
            state_in = S_STATUS;
         end
         S_SEND_STEP: begin
            cmd.op = mkte_pkg::CMD_SEND_STEP;
            if (status.send_last) begin
               state_in = S_IDLE;
            end
         end
         S_STATUS: begin
            cmd.op   = mkte_pkg::CMD_STATUS;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/mkte_dp.sv
// Editor datapath: message RAM, cursor/length/case/multitap registers, result register.
// Depends on mkte_pkg and mkte_ram.
module mkte_dp #(
   parameter int MSG_CAPACITY = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mkte_pkg::dp_cmd_type    cmd,
   output mkte_pkg::dp_status_type status,
   input  mkte_pkg::req_item_type  req_item,
   input  logic [15:0]             csr_data,
   output logic                    rsp_valid,
   output mkte_pkg::rsp_item_type  rsp_item
);

   localparam int CW = $clog2(MSG_CAPACITY + 1);
   localparam int AW = (MSG_CAPACITY > 1) ? $clog2(MSG_CAPACITY) : 1;
   localparam logic [CW-1:0] CAP   = CW'(MSG_CAPACITY);
   localparam logic [CW-1:0] ONE   = CW'(1);
   localparam logic [CW:0]   ONE_X = (CW+1)'(1);
   localparam logic [CW:0]   TWO_X = (CW+1)'(2);

   mkte_pkg::req_item_type req_ff;
   mkte_pkg::rsp_item_type rsp_ff, rsp_in;
   logic [CW-1:0] cursor_ff, length_ff, idx_ff;
   logic          upper_ff;
   logic [4:0]    prev_ff;
   logic [2:0]    pos_ff;
   logic [15:0]   count_ff, timeout_ff;
   logic          rsp_valid_ff;

   logic [CW:0]   cursor_x, length_x, idx_x;
   logic [3:0]    key;
   logic          cmd_key;
   logic [2:0]    pos_inc, pos_next;
   logic          pending;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [6:0]    wr_data, rd_data;

   assign key      = req_ff.key_code;
   assign cursor_x = {1'b0, cursor_ff};
   assign length_x = {1'b0, length_ff};
   assign idx_x    = {1'b0, idx_ff};
   assign pos_inc  = pos_ff + 3'd1;
   assign pos_next = (pos_inc == mkte_pkg::group_len(key)) ? 3'd0 : pos_inc;
   assign pending  = (prev_ff != mkte_pkg::NO_KEY) && (count_ff != 16'd0);

   assign cmd_key = (key == mkte_pkg::KEY_LEFT) || (key == mkte_pkg::KEY_RIGHT) ||
                    (key == mkte_pkg::KEY_DEL)  || (key == mkte_pkg::KEY_CASE)  ||
                    (key == mkte_pkg::KEY_SEND) || (key == mkte_pkg::KEY_COMMIT);

   always_comb begin
      status.is_tick   = (req_ff.operation == mkte_pkg::OP_TICK);
      status.is_char   = !cmd_key;
      status.is_repeat = ({1'b0, key} == prev_ff) && (count_ff != 16'd0);
      status.key_del   = (key == mkte_pkg::KEY_DEL);
      status.is_send   = (key == mkte_pkg::KEY_SEND);
      status.full      = (length_ff == CAP);
      status.at_end    = (cursor_ff == length_ff);
      status.cur_zero  = (cursor_ff == '0);
      status.len_zero  = (length_ff == '0);
      status.ins_last  = (idx_x == cursor_x + ONE_X);
      status.del_last  = (idx_x + TWO_X == length_x);
      status.send_last = (idx_x + ONE_X == length_x);
   end

   // RAM port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(idx_x);
      wr_data = rd_data;
      rd_addr = '0;
      unique case (cmd.op)
         mkte_pkg::CMD_INS_INIT: rd_addr = AW'(length_x - ONE_X);
         mkte_pkg::CMD_INS_STEP: begin
            wr_en   = 1'b1;
            rd_addr = AW'(idx_x - TWO_X);
         end
         mkte_pkg::CMD_INS_DONE: begin
            wr_en   = !status.full;
            wr_addr = AW'(cursor_x);
            wr_data = mkte_pkg::fold_case(mkte_pkg::group_char(key, 3'd0), upper_ff);
         end
         mkte_pkg::CMD_DEL_INIT: rd_addr = AW'(cursor_x);
         mkte_pkg::CMD_DEL_STEP: begin
            wr_en   = 1'b1;
            rd_addr = AW'(idx_x + TWO_X);
         end
         mkte_pkg::CMD_REPLACE: begin
            wr_en   = !status.cur_zero;
            wr_addr = AW'(cursor_x - ONE_X);
            wr_data = mkte_pkg::fold_case(mkte_pkg::group_char(key, pos_next), upper_ff);
         end
         mkte_pkg::CMD_SEND_INIT: rd_addr = '0;
         mkte_pkg::CMD_SEND_STEP: rd_addr = AW'(idx_x + ONE_X);
         default: ;
      endcase
   end

   mkte_ram #(
      .WIDTH (7),
      .DEPTH (MSG_CAPACITY)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // editor state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         length_ff    <= '0;
         upper_ff     <= 1'b1;
         prev_ff      <= mkte_pkg::NO_KEY;
         pos_ff       <= 3'd0;
         count_ff     <= 16'd0;
         timeout_ff   <= mkte_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == mkte_pkg::CMD_SEND_STEP) ||
                         (cmd.op == mkte_pkg::CMD_STATUS);
         if (cmd.cfg_write) begin
            timeout_ff <= csr_data;
         end
         unique case (cmd.op)
            mkte_pkg::CMD_TICK: begin
               if (count_ff != 16'd0) begin
                  count_ff <= count_ff - 16'd1;
                  if (count_ff == 16'd1) begin
                     prev_ff <= mkte_pkg::NO_KEY;
                     pos_ff  <= 3'd0;
                  end
               end
            end
            mkte_pkg::CMD_SIMPLE: begin
               prev_ff  <= mkte_pkg::NO_KEY;
               pos_ff   <= 3'd0;
               count_ff <= 16'd0;
               if (key == mkte_pkg::KEY_LEFT && cursor_ff != '0) begin
                  cursor_ff <= cursor_ff - ONE;
               end
               if (key == mkte_pkg::KEY_RIGHT && cursor_ff < length_ff) begin
                  cursor_ff <= cursor_ff + ONE;
               end
               if (key == mkte_pkg::KEY_CASE) begin
                  upper_ff <= !upper_ff;
               end
            end
            mkte_pkg::CMD_REPLACE: begin
               pos_ff   <= pos_next;
               count_ff <= timeout_ff;
            end
            mkte_pkg::CMD_INS_DONE: begin
               if (!status.full) begin
                  length_ff <= length_ff + ONE;
                  cursor_ff <= cursor_ff + ONE;
               end
               prev_ff  <= (timeout_ff == 16'd0) ? mkte_pkg::NO_KEY : {1'b0, key};
               pos_ff   <= 3'd0;
               count_ff <= timeout_ff;
            end
            mkte_pkg::CMD_DEL_INIT, mkte_pkg::CMD_SEND_INIT: begin
               prev_ff  <= mkte_pkg::NO_KEY;
               pos_ff   <= 3'd0;
               count_ff <= 16'd0;
            end
            mkte_pkg::CMD_DEL_DONE: begin
               prev_ff   <= mkte_pkg::NO_KEY;
               pos_ff    <= 3'd0;
               count_ff  <= 16'd0;
               length_ff <= length_ff - ONE;
               cursor_ff <= cursor_ff - ONE;
            end
            mkte_pkg::CMD_SEND_STEP: begin
               if (status.send_last) begin
                  length_ff <= '0;
                  cursor_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // result payload
   always_comb begin
      rsp_in.kind        = mkte_pkg::KIND_STATUS;
      rsp_in.char_byte   = 7'h00;
      rsp_in.last_of_run = 1'b1;
      rsp_in.cursor_now  = 4'(cursor_ff);
      rsp_in.length_now  = 4'(length_ff);
      rsp_in.upper_now   = upper_ff;
      rsp_in.tap_pending = pending;
      if (cmd.op == mkte_pkg::CMD_SEND_STEP) begin
         rsp_in.kind        = mkte_pkg::KIND_BYTE;
         rsp_in.char_byte   = rd_data;
         rsp_in.last_of_run = status.send_last;
         rsp_in.cursor_now  = 4'd0;
         rsp_in.tap_pending = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_item;
      end
      unique case (cmd.op)
         mkte_pkg::CMD_INS_INIT:  idx_ff <= length_ff;
         mkte_pkg::CMD_INS_STEP:  idx_ff <= idx_ff - ONE;
         mkte_pkg::CMD_DEL_INIT:  idx_ff <= cursor_ff - ONE;
         mkte_pkg::CMD_DEL_STEP:  idx_ff <= idx_ff + ONE;
         mkte_pkg::CMD_SEND_INIT: idx_ff <= '0;
         mkte_pkg::CMD_SEND_STEP: idx_ff <= idx_ff + ONE;
         default: ;
      endcase
      if ((cmd.op == mkte_pkg::CMD_SEND_STEP) || (cmd.op == mkte_pkg::CMD_STATUS)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### design/multitap_keypad_text_editor.sv
// Timing: a tick keeps busy high only through the decode state.
// A plain key runs decode, then status; its status strobe is registered from that state.
// Insert/delete run decode, a shift step (one RAM write) per shifted character, then
// finish and status; decode finishes at once when nothing moves. Send: a byte a cycle.
// Synchronous active-high reset: empty message, upper case, no pending tap, timeout 800.
// Results are single-cycle strobes; the receiver cannot stall them.
module multitap_keypad_text_editor #(
   parameter int MSG_CAPACITY = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  mkte_pkg::req_item_type req_item,
   // result channel
   output logic                   rsp_valid,
   output mkte_pkg::rsp_item_type rsp_item,
   // timeout register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);

   // Command/status pair is the only link between the sequencer and the datapath.
   mkte_pkg::dp_cmd_type    cmd;
   mkte_pkg::dp_status_type status;

   // Sequencer: accepts a request when idle, then walks the shift or send loop
   // one RAM access per cycle. The register port is open only while idle.
   mkte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: message RAM (registered read), editor state and the result
   // register that drives the strobe.
   mkte_dp #(
      .MSG_CAPACITY (MSG_CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### design/mkte_chk.sv
// Port-level checker for the multitap editor, bound to the top level.
// Depends on mkte_pkg.
module mkte_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input mkte_pkg::rsp_item_type rsp_item,
   input logic                   csr_ready
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind == mkte_pkg::KIND_STATUS |->
         rsp_item.char_byte == 7'h00 && rsp_item.last_of_run)
      else $error("status result malformed");

   a_byte_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind == mkte_pkg::KIND_BYTE |->
         rsp_item.cursor_now == 4'd0 && !rsp_item.tap_pending)
      else $error("sent byte carries editor state");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_of_run |=> !rsp_valid)
      else $error("result after end of run");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy)
      else $error("register port open while busy");

endmodule

bind multitap_keypad_text_editor mkte_chk u_mkte_chk (.*);

### sim/tb_multitap_keypad_text_editor.sv
// Self-checking testbench for the multitap keypad text editor.
// Depends on design/mkte_pkg.sv and design/multitap_keypad_text_editor.sv;
// key presses and ticks are predicted in-bench and checked against every strobe.
module tb_multitap_keypad_text_editor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = 13;
   localparam int SETTLE_CYCLES  = 24;    // longer than the slowest insert/delete/send
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_PRESSES  = 20;

   // one queued action: either a request for the editor or a timeout register write
   typedef struct {
      bit                     is_cfg;
      mkte_pkg::req_item_type req;
      logic [15:0]            cfg_value;
      int                     gap;
   } key_action_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   mkte_pkg::req_item_type req_item  = '0;
   logic                   rsp_valid;
   mkte_pkg::rsp_item_type rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [15:0]            csr_data  = '0;

   multitap_keypad_text_editor #(.MSG_CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ------------------------------------------------------------------
   // Editor shadow state: what the block should hold after each request
   // ------------------------------------------------------------------
   logic [6:0]  text_buf [0:CAPACITY-1];
   int          caret         = 0;
   int          msg_len       = 0;
   logic        upper_mode    = 1'b1;
   logic [4:0]  last_key      = mkte_pkg::NO_KEY;
   int          tap_index     = 0;
   int          countdown     = 0;
   logic [15:0] timeout_ticks = mkte_pkg::TIMEOUT_RESET;

   mkte_pkg::rsp_item_type editor_rsp_due [$];   // results owed by the editor, oldest first
   key_action_type backlog [$];                  // actions not yet offered to the block
   logic [3:0] char_keys [0:9] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9,
                                   4'd10, 4'd13};

   int  mismatch_count = 0;
   int  presses_queued = 0;
   bit  calm_stretch   = 1'b0;

   // letters cycled by each character key; empty for command keys
   function automatic string key_letters(input logic [3:0] key);
      case (key)
         4'd0:    return "1.,!?";
         4'd1:    return "ABC2";
         4'd2:    return "DEF3";
         4'd4:    return "GHI4";
         4'd5:    return "JKL5";
         4'd6:    return "MNO6";
         4'd8:    return "PQRS7";
         4'd9:    return "TUV8";
         4'd10:   return "WXYZ9";
         4'd13:   return " 0";
         default: return "";
      endcase
   endfunction

   function automatic logic [6:0] as_typed(input byte c, input logic upper);
      logic [6:0] ch;
      ch = c[6:0];
      if (!upper && ch >= mkte_pkg::CHAR_UPPER_A && ch <= mkte_pkg::CHAR_UPPER_Z) begin
         ch = ch + mkte_pkg::CASE_OFFSET;
      end
      return ch;
   endfunction

   task automatic drop_tap();
      last_key  = mkte_pkg::NO_KEY;
      tap_index = 0;
      countdown = 0;
   endtask

   // Advance the shadow editor by one accepted request and queue what it owes.
   task automatic apply_keypad_event(input mkte_pkg::req_item_type ev);
      int                     i;
      int                     glen;
      string                  grp;
      mkte_pkg::rsp_item_type r;
      if (ev.operation == mkte_pkg::OP_TICK) begin
         // ticks never answer; they only run the multitap timeout down
         if (countdown > 0) begin
            countdown--;
            if (countdown == 0) begin
               drop_tap();
            end
         end
         return;
      end
      case (ev.key_code)
         mkte_pkg::KEY_LEFT: begin
            drop_tap();
            if (caret > 0) begin
               caret--;
            end
         end
         mkte_pkg::KEY_RIGHT: begin
            drop_tap();
            if (caret < msg_len) begin
               caret++;
            end
         end
         mkte_pkg::KEY_DEL: begin
            drop_tap();
            if (caret > 0 && msg_len > 0) begin
               for (i = caret - 1; i + 1 < msg_len; i++) begin
                  text_buf[i] = text_buf[i + 1];
               end
               msg_len--;
               caret--;
            end
         end
         mkte_pkg::KEY_CASE: begin
            drop_tap();
            upper_mode = !upper_mode;
         end
         mkte_pkg::KEY_SEND: begin
            drop_tap();
            if (msg_len > 0) begin
               // one byte per character, no status; the last byte closes the run
               for (i = 0; i < msg_len; i++) begin
                  r.kind        = mkte_pkg::KIND_BYTE;
                  r.char_byte   = text_buf[i];
                  r.last_of_run = (i + 1 == msg_len);
                  r.cursor_now  = '0;
                  r.length_now  = 4'(msg_len);
                  r.upper_now   = upper_mode;
                  r.tap_pending = 1'b0;
                  editor_rsp_due.push_back(r);
               end
               msg_len = 0;
               caret   = 0;
               return;
            end
         end
         mkte_pkg::KEY_COMMIT: begin
            drop_tap();
         end
         default: begin
            grp  = key_letters(ev.key_code);
            glen = grp.len();
            if ({1'b0, ev.key_code} == last_key && countdown > 0) begin
               // repeat inside the timeout: cycle and overwrite the char left of the cursor
               tap_index = (tap_index + 1) % glen;
               if (caret > 0) begin
                  text_buf[caret - 1] = as_typed(grp[tap_index], upper_mode);
               end
               countdown = timeout_ticks;
            end else begin
               drop_tap();
               if (msg_len < CAPACITY) begin
                  for (i = msg_len; i > caret; i--) begin
                     text_buf[i] = text_buf[i - 1];
                  end
                  text_buf[caret] = as_typed(grp[0], upper_mode);
                  msg_len++;
                  caret++;
               end
               // armed even when full, so a repeat still overwrites
               last_key  = {1'b0, ev.key_code};
               countdown = timeout_ticks;
               if (countdown == 0) begin
                  drop_tap();
               end
            end
         end
      endcase
      r.kind        = mkte_pkg::KIND_STATUS;
      r.char_byte   = '0;
      r.last_of_run = 1'b1;
      r.cursor_now  = 4'(caret);
      r.length_now  = 4'(msg_len);
      r.upper_now   = upper_mode;
      r.tap_pending = (last_key != mkte_pkg::NO_KEY && countdown > 0);
      editor_rsp_due.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic push_event(input logic op, input logic [3:0] key);
      key_action_type a;
      a.is_cfg      = 1'b0;
      a.req.operation = op;
      a.req.key_code  = key;
      a.cfg_value   = '0;
      a.gap         = calm_stretch ? 0 : $urandom_range(0, 11);
      backlog.push_back(a);
      if (op == mkte_pkg::OP_KEY) begin
         presses_queued++;
      end
   endtask

   task automatic push_timeout(input logic [15:0] value);
      key_action_type a;
      a.is_cfg    = 1'b1;
      a.req       = '0;
      a.cfg_value = value;
      a.gap       = $urandom_range(0, 11);
      backlog.push_back(a);
   endtask

   task automatic push_ticks(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         push_event(mkte_pkg::OP_TICK, 4'($urandom_range(0, 15)));
      end
   endtask

   function automatic logic [3:0] pick_char_key();
      return char_keys[$urandom_range(0, 9)];
   endfunction

   // One random chunk: mostly well-formed typing, some editing and sends, a bit of noise.
   task automatic push_random_chunk();
      int         sel;
      int         k;
      logic [3:0] key;
      logic [3:0] prev;
      calm_stretch = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         // a letter: first tap plus a few repeats, then maybe let it time out
         key = pick_char_key();
         for (k = $urandom_range(1, 6); k > 0; k--) begin
            push_event(mkte_pkg::OP_KEY, key);
         end
         push_ticks($urandom_range(0, 6));
      end else if (sel < 52) begin
         push_ticks($urandom_range(1, 6));
      end else if (sel < 63) begin
         for (k = $urandom_range(1, 3); k > 0; k--) begin
            push_event(mkte_pkg::OP_KEY,
                       $urandom_range(0, 1) ? mkte_pkg::KEY_LEFT : mkte_pkg::KEY_RIGHT);
         end
      end else if (sel < 70) begin
         for (k = $urandom_range(1, 2); k > 0; k--) begin
            push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_DEL);
         end
      end else if (sel < 75) begin
         push_event(mkte_pkg::OP_KEY,
                    $urandom_range(0, 1) ? mkte_pkg::KEY_CASE : mkte_pkg::KEY_COMMIT);
      end else if (sel < 81) begin
         push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_SEND);
      end else if (sel < 85) begin
         // fill to capacity, each key unlike the one before, walk left (often to the start),
         // then tap one key twice so the full-message and cursor-at-start repeats show up
         prev = mkte_pkg::KEY_COMMIT;
         for (k = 0; k < CAPACITY + 1; k++) begin
            do begin
               key = pick_char_key();
            end while (key == prev);
            push_event(mkte_pkg::OP_KEY, key);
            prev = key;
         end
         for (k = $urandom_range(0, 1) ? CAPACITY : $urandom_range(0, CAPACITY); k > 0; k--)
         begin
            push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_LEFT);
         end
         key = pick_char_key();
         push_event(mkte_pkg::OP_KEY, key);
         push_event(mkte_pkg::OP_KEY, key);
      end else begin
         for (k = $urandom_range(1, 4); k > 0; k--) begin
            push_event(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: offers the backlog one action at a time, predicts on accept
   // ------------------------------------------------------------------
   key_action_type cur_action;
   bit offering     = 1'b0;
   int hold_off     = 0;
   int settle_count = 0;
   bit took_req;
   bit took_cfg;

   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         offering     = 1'b0;
         hold_off     = 0;
         settle_count = 0;
      end else begin
         took_req = start && !busy;
         took_cfg = csr_valid && csr_ready;
         if (took_req) begin
            apply_keypad_event(cur_action.req);
            offering = 1'b0;
         end
         if (took_cfg) begin
            timeout_ticks = cur_action.cfg_value;
            offering      = 1'b0;
         end
         if (took_req || took_cfg) begin
            hold_off = (backlog.size() > 0) ? backlog[0].gap : 0;
         end
         // quiet time since the block last did anything visible
         settle_count = (busy || rsp_valid || took_req) ? 0 : settle_count + 1;
         if (!offering && backlog.size() > 0) begin
            if (hold_off > 0) begin
               hold_off--;
            end else if (!backlog[0].is_cfg ||
                         (editor_rsp_due.size() == 0 && settle_count >= SETTLE_CYCLES)) begin
               // register writes only go out once the editor has fully drained
               cur_action = backlog.pop_front();
               offering   = 1'b1;
            end
         end
         // exactly one nonblocking update per signal, so start stays high back to back
         start     <= offering && !cur_action.is_cfg;
         csr_valid <= offering && cur_action.is_cfg;
         req_item  <= cur_action.req;
         csr_data  <= cur_action.cfg_value;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every strobe is matched against the oldest owed result
   // ------------------------------------------------------------------
   mkte_pkg::rsp_item_type owed;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (editor_rsp_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result %p", rsp_item);
            end
         end else begin
            owed = editor_rsp_due.pop_front();
            if (rsp_item.kind        !== owed.kind        ||
                rsp_item.char_byte   !== owed.char_byte   ||
                rsp_item.last_of_run !== owed.last_of_run ||
                rsp_item.cursor_now  !== owed.cursor_now  ||
                rsp_item.length_now  !== owed.length_now  ||
                rsp_item.upper_now   !== owed.upper_now   ||
                rsp_item.tap_pending !== owed.tap_pending) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch: expected %p", owed);
                  $display("                 actual   %p", rsp_item);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without an accepted request or register write ends the run
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   logic [15:0] phase_timeouts [0:6];
   int          p;

   initial begin
      // directed opening, default timeout of 800 so taps stay pending
      calm_stretch = 1'b1;
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_SEND);    // send on empty message
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_LEFT);    // left at start
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_DEL);     // delete at start
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_RIGHT);   // right at end
      calm_stretch = 1'b0;
      repeat (5) push_event(mkte_pkg::OP_KEY, 4'd1);       // A B C 2 and wrap back to A
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_CASE);    // to lower case
      push_event(mkte_pkg::OP_KEY, 4'd0);                  // punctuation group
      push_event(mkte_pkg::OP_KEY, 4'd9);                  // lower-case letter
      push_event(mkte_pkg::OP_KEY, 4'd13);                 // space
      push_event(mkte_pkg::OP_KEY, 4'd13);                 // cycles to digit
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_LEFT);
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_DEL);     // delete in the middle
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_COMMIT);
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_RIGHT);
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_CASE);    // back to upper case
      push_event(mkte_pkg::OP_KEY, 4'd10);
      push_ticks(1);
      push_event(mkte_pkg::OP_KEY, 4'd10);
      push_event(mkte_pkg::OP_KEY, mkte_pkg::KEY_SEND);
      push_event(mkte_pkg::OP_TICK, 4'hF);

      // random phases, each under its own timeout; extremes and zero included
      phase_timeouts = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd5, 16'd4};
      phase_timeouts[6] = 16'($urandom_range(2, 9));
      for (p = 0; p < 7; p++) begin
         push_timeout(phase_timeouts[p]);
         presses_queued = 0;
         while (presses_queued < PHASE_PRESSES) begin
            push_random_chunk();
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (backlog.size() > 0 || offering || editor_rsp_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
